// ===== src/tiar_pkg.sv =====
package tiar_pkg;

    // Word sizes used throughout the datapath.
    localparam int WORD_W   = 64;
    localparam int DWORD_W  = 128;
    localparam int HALF_W   = 32;
    localparam int LIMB_W   = 16;
    localparam int CLOCK_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int U16_W    = 16;
    localparam int U32_W    = 32;

    // Bit of the full u128 multiply accumulator that raises the carry flag.
    localparam int CARRY_POS = 193;

    // Three 64x64 products, each built from four 32x32 partial products.
    localparam int N_PROD = 3;
    localparam int N_PART = 4;

    // Product slots: low x low, high half of a times low of b, low of a times high of b.
    localparam int PROD_LL = 0;
    localparam int PROD_HL = 1;
    localparam int PROD_LH = 2;

    // Partial product slots inside one 64x64 product.
    localparam int PART_00 = 0;
    localparam int PART_01 = 1;
    localparam int PART_10 = 2;
    localparam int PART_11 = 3;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // Width tags.
    localparam logic [2:0] TAG_U8   = 3'd0;
    localparam logic [2:0] TAG_U16  = 3'd1;
    localparam logic [2:0] TAG_U32  = 3'd2;
    localparam logic [2:0] TAG_U64  = 3'd3;
    localparam logic [2:0] TAG_U128 = 3'd4;

    // Row kinds.
    localparam logic [1:0] ROW_MAIN   = 2'd0;
    localparam logic [1:0] ROW_SECOND = 2'd1;
    localparam logic [1:0] ROW_UNSUP  = 2'd2;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [DWORD_W-1:0] dword_t;

    // Input data word, last field in the lowest bits.
    typedef struct packed {
        logic [5:0]         pad;
        logic [CLOCK_W-1:0] clock_stamp;
        word_t              b_high;
        word_t              b_low;
        word_t              a_high;
        word_t              a_low;
        logic [1:0]         opcode;
    } in_data_t;

    // Output data word, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]         pad;
        word_t              partial_word;
        word_t              limbs_high;
        word_t              limbs_low;
        logic [BYTE_W-1:0]  byte_reg_one;
        logic [BYTE_W-1:0]  byte_reg_zero;
        logic               carry_flag;
        word_t              result_high;
        word_t              result_low;
        logic [CLOCK_W-1:0] row_clock;
    } out_row_t;

    // Decoded item that travels down the pipeline.
    typedef struct packed {
        logic               unsup;
        logic [1:0]         opcode;
        logic [2:0]         tag;
        logic [CLOCK_W-1:0] clock;
        dword_t             opa;
        dword_t             opb;
        logic [DWORD_W:0]   sum;
        logic [DWORD_W:0]   diff;
    } item_t;

    typedef logic [N_PROD-1:0][N_PART-1:0][WORD_W-1:0] part_bank_t;
    typedef logic [N_PROD-1:0][DWORD_W-1:0]             prod_bank_t;

    // Mask of the operand bits that a narrow tag keeps.
    function automatic word_t tag_mask(input logic [2:0] tag);
        word_t m;
        case (tag)
            TAG_U8:  m = word_t'({BYTE_W{1'b1}});
            TAG_U16: m = word_t'({U16_W{1'b1}});
            TAG_U32: m = word_t'({U32_W{1'b1}});
            default: m = '1;
        endcase
        return m;
    endfunction

endpackage

// ===== src/tiar_front.sv =====
module tiar_front
    import tiar_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         width_tag,
    input  word_t              a_low,
    input  word_t              a_high,
    input  word_t              b_low,
    input  word_t              b_high,
    input  logic [CLOCK_W-1:0] clock_stamp,
    output logic               out_valid,
    input  logic               out_ready,
    output item_t              out_item,
    output part_bank_t         out_parts
);

    logic       valid_reg;
    item_t      item_reg;
    item_t      item_next;
    part_bank_t parts_reg;
    part_bank_t parts_next;
    word_t      mask;
    logic       is_wide;
    word_t      fx [N_PROD];
    word_t      fy [N_PROD];

    // Decode, operand masking and the 129-bit add and subtract.
    always_comb
    begin
        mask    = tag_mask(width_tag);
        is_wide = (width_tag == TAG_U128);

        item_next.unsup  = ((opcode != OP_ADD) && (opcode != OP_SUB) && (opcode != OP_MUL))
                           || (width_tag > TAG_U128);
        item_next.opcode = opcode;
        item_next.tag    = width_tag;
        item_next.clock  = clock_stamp;
        item_next.opa    = is_wide ? {a_high, a_low} : {word_t'(0), a_low & mask};
        item_next.opb    = is_wide ? {b_high, b_low} : {word_t'(0), b_low & mask};
        item_next.sum    = {1'b0, item_next.opa} + {1'b0, item_next.opb};
        item_next.diff   = {1'b0, item_next.opa} - {1'b0, item_next.opb};
    end

    // Factor pairs of the three 64x64 products and their 32x32 partials.
    always_comb
    begin
        fx[PROD_LL] = item_next.opa[WORD_W-1:0];
        fy[PROD_LL] = item_next.opb[WORD_W-1:0];
        fx[PROD_HL] = item_next.opa[DWORD_W-1:WORD_W];
        fy[PROD_HL] = item_next.opb[WORD_W-1:0];
        fx[PROD_LH] = item_next.opa[WORD_W-1:0];
        fy[PROD_LH] = item_next.opb[DWORD_W-1:WORD_W];
        for (int k = 0; k < N_PROD; k++)
        begin
            parts_next[k][PART_00] = fx[k][HALF_W-1:0]      * fy[k][HALF_W-1:0];
            parts_next[k][PART_01] = fx[k][HALF_W-1:0]      * fy[k][WORD_W-1:HALF_W];
            parts_next[k][PART_10] = fx[k][WORD_W-1:HALF_W] * fy[k][HALF_W-1:0];
            parts_next[k][PART_11] = fx[k][WORD_W-1:HALF_W] * fy[k][WORD_W-1:HALF_W];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_parts = parts_reg;

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg  <= item_next;
            parts_reg <= parts_next;
        end
    end

endmodule

// ===== src/tiar_mul_tree.sv =====
module tiar_mul_tree
    import tiar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    input  part_bank_t       in_parts,
    output logic             out_valid,
    input  logic             out_ready,
    output item_t            out_item,
    output dword_t           out_prod,
    output logic [DWORD_W:0] out_cross
);

    logic             s2_valid_reg;
    item_t            s2_item_reg;
    prod_bank_t       s2_prod_reg;
    prod_bank_t       s2_prod_next;
    logic             s2_ready;
    logic             s3_valid_reg;
    item_t            s3_item_reg;
    dword_t           s3_prod_reg;
    logic [DWORD_W:0] s3_cross_reg;
    logic [DWORD_W:0] s3_cross_next;
    logic             s3_ready;

    // Fold four partial products into each 128-bit product.
    always_comb
    begin
        for (int k = 0; k < N_PROD; k++)
        begin
            s2_prod_next[k] = {in_parts[k][PART_11], in_parts[k][PART_00]}
                            + (dword_t'(in_parts[k][PART_01]) << HALF_W)
                            + (dword_t'(in_parts[k][PART_10]) << HALF_W);
        end
    end

    // Sum of the two cross products, weighted by 2^64 later.
    assign s3_cross_next = {1'b0, s2_prod_reg[PROD_HL]} + {1'b0, s2_prod_reg[PROD_LH]};

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign in_ready  = s2_ready;
    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;
    assign out_prod  = s3_prod_reg;
    assign out_cross = s3_cross_reg;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_valid && s2_ready)
        begin
            s2_item_reg <= in_item;
            s2_prod_reg <= s2_prod_next;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_item_reg  <= s2_item_reg;
            s3_prod_reg  <= s2_prod_reg[PROD_LL];
            s3_cross_reg <= s3_cross_next;
        end
    end

endmodule

// ===== src/tiar_row_out.sv =====
module tiar_row_out
    import tiar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    input  dword_t           in_prod,
    input  logic [DWORD_W:0] in_cross,
    output logic             m_tvalid,
    input  logic             m_tready,
    output out_row_t         m_row,
    output logic [1:0]       m_kind
);

    logic               valid_reg;
    logic               valid_next;
    logic               pending_reg;
    logic               pending_next;
    logic [1:0]         kind_reg;
    logic [1:0]         kind_next;
    out_row_t           row_reg;
    out_row_t           row_next;
    dword_t             limbs_b_reg;
    dword_t             limbs_b_next;

    out_row_t           new_row;
    logic [1:0]         new_kind;
    logic               new_two;
    word_t              mask;
    logic               is_wide;
    logic [DWORD_W+1:0] w_upper;
    word_t              rl;
    word_t              rh;
    logic               cf;
    logic [BYTE_W-1:0]  b1;
    word_t              ll;
    word_t              lh;

    // Final accumulator add and assembly of the first row.
    always_comb
    begin
        mask     = tag_mask(in_item.tag);
        is_wide  = (in_item.tag == TAG_U128);
        w_upper  = {{(DWORD_W-WORD_W+2){1'b0}}, in_prod[DWORD_W-1:WORD_W]}
                 + {1'b0, in_cross};
        new_row  = '0;
        new_kind = ROW_MAIN;
        new_two  = 1'b0;
        rl       = '0;
        rh       = '0;
        cf       = 1'b0;
        b1       = '0;
        ll       = '0;
        lh       = '0;

        if (in_item.unsup)
        begin
            new_kind = ROW_UNSUP;
        end
        else if (is_wide && (in_item.opcode == OP_MUL))
        begin
            // Main row of a u128 multiply; the limbs of b follow in a second row.
            new_two              = 1'b1;
            new_row.row_clock    = in_item.clock;
            new_row.result_low   = in_prod[WORD_W-1:0];
            new_row.result_high  = w_upper[WORD_W-1:0];
            new_row.carry_flag   = w_upper[CARRY_POS-WORD_W];
            new_row.limbs_low    = in_item.opa[WORD_W-1:0];
            new_row.limbs_high   = in_item.opa[DWORD_W-1:WORD_W];
            new_row.partial_word = w_upper[DWORD_W-1:WORD_W];
        end
        else
        begin
            case (in_item.opcode)
                OP_ADD:
                begin
                    rl = in_item.sum[WORD_W-1:0] & mask;
                    rh = is_wide ? in_item.sum[DWORD_W-1:WORD_W] : '0;
                    case (in_item.tag)
                        TAG_U8:  cf = in_item.sum[BYTE_W];
                        TAG_U16: cf = in_item.sum[U16_W];
                        TAG_U32: cf = in_item.sum[U32_W];
                        default: cf = is_wide ? in_item.sum[DWORD_W] : in_item.sum[WORD_W];
                    endcase
                    ll = rl;
                    lh = rh;
                end
                OP_SUB:
                begin
                    rl = in_item.diff[WORD_W-1:0] & mask;
                    rh = is_wide ? in_item.diff[DWORD_W-1:WORD_W] : '0;
                    cf = in_item.diff[DWORD_W];
                    ll = in_item.opa[WORD_W-1:0];
                    lh = in_item.opa[DWORD_W-1:WORD_W];
                end
                default:
                begin
                    // Narrow multiply: the limbs hold the full product.
                    rl = in_prod[WORD_W-1:0] & mask;
                    ll = in_prod[WORD_W-1:0];
                    lh = in_prod[DWORD_W-1:WORD_W];
                    if (in_item.tag == TAG_U8)
                    begin
                        b1 = in_prod[2*BYTE_W-1:BYTE_W];
                    end
                end
            endcase

            new_row.row_clock    = in_item.clock;
            new_row.result_low   = rl;
            new_row.result_high  = rh;
            new_row.carry_flag   = cf;
            new_row.byte_reg_one = b1;
            if (in_item.tag == TAG_U8)
            begin
                // Byte operations keep their witness in the byte registers.
                new_row.byte_reg_zero = ll[BYTE_W-1:0];
            end
            else
            begin
                new_row.limbs_low  = ll;
                new_row.limbs_high = lh;
            end
        end
    end

    // A new item enters only when no second row is still owed.
    assign in_ready = !valid_reg || (m_tready && !pending_reg);

    // Output register sequencing.
    always_comb
    begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        kind_next    = kind_reg;
        row_next     = row_reg;
        limbs_b_next = limbs_b_reg;
        if (in_valid && in_ready)
        begin
            valid_next   = 1'b1;
            pending_next = new_two;
            kind_next    = new_kind;
            row_next     = new_row;
            limbs_b_next = in_item.opb;
        end
        else if (valid_reg && m_tready)
        begin
            if (pending_reg)
            begin
                pending_next        = 1'b0;
                kind_next           = ROW_SECOND;
                row_next            = '0;
                row_next.limbs_low  = limbs_b_reg[WORD_W-1:0];
                row_next.limbs_high = limbs_b_reg[DWORD_W-1:WORD_W];
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        row_reg     <= row_next;
        limbs_b_reg <= limbs_b_next;
    end

    assign m_tvalid = valid_reg;
    assign m_row    = row_reg;
    assign m_kind   = kind_reg;

endmodule

// ===== src/tagged_int_alu_trace_rows_top.sv =====
// Path: a result row is registered in the front, fold, cross-sum and output stages in turn.
// Throughput: one input item per cycle while the output is not stalled; a u128 multiply
// occupies the output for two rows, set by the single output register.
// Pipeline: 32x32 partial products, 64x64 product fold, cross sum, final row.
// Reset: rst_n is asynchronous and active low; it empties every stage.
module tagged_int_alu_trace_rows_top
    import tiar_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, a_low, a_high, b_low, b_high, clock_stamp, zero fill
    input  logic [295:0] s_tdata,
    // width_tag
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_clock, result_low, result_high, carry_flag, byte_reg_zero,
    // byte_reg_one, limbs_low, limbs_high, partial_word, zero fill
    output logic [375:0] m_tdata,
    // row_kind
    output logic [1:0]   m_tuser
);

    in_data_t         in_data;
    logic             fr_valid;
    logic             fr_ready;
    item_t            fr_item;
    part_bank_t       fr_parts;
    logic             mt_valid;
    logic             mt_ready;
    item_t            mt_item;
    dword_t           mt_prod;
    logic [DWORD_W:0] mt_cross;
    out_row_t         out_row;

    assign in_data = in_data_t'(s_tdata);

    // Stage 1: decode, add and subtract, partial products.
    tiar_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .opcode      (in_data.opcode),
        .width_tag   (s_tuser),
        .a_low       (in_data.a_low),
        .a_high      (in_data.a_high),
        .b_low       (in_data.b_low),
        .b_high      (in_data.b_high),
        .clock_stamp (in_data.clock_stamp),
        .out_valid   (fr_valid),
        .out_ready   (fr_ready),
        .out_item    (fr_item),
        .out_parts   (fr_parts)
    );

    // Stages 2 and 3: product fold and cross-term sum.
    tiar_mul_tree u_mul_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .in_parts  (fr_parts),
        .out_valid (mt_valid),
        .out_ready (mt_ready),
        .out_item  (mt_item),
        .out_prod  (mt_prod),
        .out_cross (mt_cross)
    );

    // Stage 4: final add, row assembly and output register.
    tiar_row_out u_row_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mt_valid),
        .in_ready (mt_ready),
        .in_item  (mt_item),
        .in_prod  (mt_prod),
        .in_cross (mt_cross),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_row    (out_row),
        .m_kind   (m_tuser)
    );

    assign m_tdata = out_row;

endmodule

// ===== src/tiar_checker.sv =====
module tiar_checker
    import tiar_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [375:0] m_tdata,
    input logic [1:0]   m_tuser
);

    out_row_t row;

    assign row = out_row_t'(m_tdata);

    // The output side is empty right after reset.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

    // A stalled result holds still.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output changed");

    // An unsupported row carries nothing but its kind.
    a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ROW_UNSUP) |-> (m_tdata == '0))
        else $error("unsupported row has nonzero data");

    // A second row carries only the limbs of b, and follows a main row.
    a_second_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ROW_SECOND) |->
            (row.row_clock == '0) && (row.result_low == '0) && (row.result_high == '0)
            && !row.carry_flag && (row.partial_word == '0)
            && $past(m_tvalid) && ($past(m_tuser) == ROW_MAIN || $past(m_tuser) == ROW_SECOND))
        else $error("second row malformed or out of order");

endmodule

bind tagged_int_alu_trace_rows_top tiar_checker u_checker (.*);

// ===== test/tb_tagged_int_alu_trace_rows_top.sv =====
`timescale 1ns / 100ps

module tb_tagged_int_alu_trace_rows_top;
    import tiar_pkg::*;

    // Codes outside the package's named set.
    localparam logic [1:0] OP_BAD    = 2'd3;
    localparam logic [2:0] TAG_FIELD = 3'd5;
    localparam logic [2:0] TAG_NONE  = 3'd6;
    localparam logic [2:0] TAG_SEVEN = 3'd7;

    localparam word_t ONES         = '1;
    localparam int    ITEMS_PER_PH = 406;
    localparam int    HOLD_CYCLES  = 200;
    localparam int    QUIET_LIMIT  = 3000;

    // One expected row: kind as carried on tuser, fields as carried on tdata.
    typedef struct packed {
        logic [1:0] kind;
        out_row_t   row;
    } trace_row_t;

    // One ALU instruction, with an optional typed-in expectation.
    typedef struct {
        logic [1:0]  op;
        logic [2:0]  tag;
        word_t       al;
        word_t       ah;
        word_t       bl;
        word_t       bh;
        logic [31:0] stamp;
        bit          typed;
        trace_row_t  known;
    } alu_op_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [295:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [375:0] m_tdata;
    logic [1:0]   m_tuser;

    trace_row_t pending_rows[$];
    alu_op_t    directed_ops[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int quiet_cycles   = 0;
    int n_errors       = 0;
    int n_items        = 0;
    int n_directed     = 0;
    int n_main         = 0;
    int n_second       = 0;
    int n_unsup        = 0;
    int n_holds        = 0;

    tagged_int_alu_trace_rows_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Computes the witness rows of one instruction; returns how many there are.
    function automatic int predict_trace_rows(input logic [1:0] op, input logic [2:0] tag,
                                              input in_data_t d, output trace_row_t r0,
                                              output trace_row_t r1);
        word_t        m;
        word_t        al;
        word_t        bl;
        logic [128:0] wide;
        logic [127:0] prod;
        logic [255:0] acc;
        out_row_t     o;
        o  = '0;
        r0 = '0;
        r1 = '0;
        // Reserved opcode and the field, none and spare tags give one empty row.
        if (op == OP_BAD || tag > TAG_U128)
        begin
            r0.kind = ROW_UNSUP;
            return 1;
        end
        o.row_clock = d.clock_stamp;
        r0.kind     = ROW_MAIN;
        if (tag == TAG_U128)
        begin
            if (op == OP_ADD)
            begin
                wide = {1'b0, d.a_high, d.a_low} + {1'b0, d.b_high, d.b_low};
                {o.result_high, o.result_low} = wide[127:0];
                {o.limbs_high, o.limbs_low}   = wide[127:0];
                o.carry_flag = wide[128];
            end
            else if (op == OP_SUB)
            begin
                wide = {1'b0, d.a_high, d.a_low} - {1'b0, d.b_high, d.b_low};
                {o.result_high, o.result_low} = wide[127:0];
                o.carry_flag = wide[128];
                o.limbs_low  = d.a_low;
                o.limbs_high = d.a_high;
            end
            else
            begin
                // Full a times b_low plus the a_low times b_high cross term.
                acc = 256'({d.a_high, d.a_low}) * 256'(d.b_low)
                    + ((256'(d.a_low) * 256'(d.b_high)) << 64);
                o.result_low   = acc[63:0];
                o.result_high  = acc[127:64];
                o.partial_word = acc[191:128];
                o.carry_flag   = |acc[255:193];
                o.limbs_low    = d.a_low;
                o.limbs_high   = d.a_high;
                r0.row         = o;
                r1.kind            = ROW_SECOND;
                r1.row.limbs_low   = d.b_low;
                r1.row.limbs_high  = d.b_high;
                return 2;
            end
            r0.row = o;
            return 1;
        end
        // Narrow tags work on the low bits only.
        case (tag)
            TAG_U8:  m = 64'hFF;
            TAG_U16: m = 64'hFFFF;
            TAG_U32: m = 64'hFFFF_FFFF;
            default: m = ONES;
        endcase
        al = d.a_low & m;
        bl = d.b_low & m;
        if (op == OP_ADD)
        begin
            o.result_low = (al + bl) & m;
            o.carry_flag = (o.result_low < al);
            o.limbs_low  = o.result_low;
        end
        else if (op == OP_SUB)
        begin
            o.result_low = (al - bl) & m;
            o.carry_flag = (al < bl);
            o.limbs_low  = al;
        end
        else
        begin
            prod         = 128'(al) * 128'(bl);
            o.result_low = prod[63:0] & m;
            o.limbs_low  = prod[63:0];
            o.limbs_high = prod[127:64];
            if (tag == TAG_U8)
                o.byte_reg_one = prod[15:8];
        end
        // The u8 witness lives in the byte registers instead of the limbs.
        if (tag == TAG_U8)
        begin
            o.byte_reg_zero = o.limbs_low[7:0];
            o.limbs_low     = '0;
            o.limbs_high    = '0;
        end
        r0.row = o;
        return 1;
    endfunction

    // Appends one row to the directed table.
    task automatic add_directed(input bit typed, input logic [1:0] op, input logic [2:0] tag,
                                input word_t al, input word_t ah, input word_t bl,
                                input word_t bh, input logic [31:0] stamp,
                                input logic [1:0] kind, input word_t rl, input word_t rh,
                                input logic cf, input logic [7:0] b0, input logic [7:0] b1,
                                input word_t ll, input word_t lh);
        alu_op_t p;
        p.op    = op;
        p.tag   = tag;
        p.al    = al;
        p.ah    = ah;
        p.bl    = bl;
        p.bh    = bh;
        p.stamp = stamp;
        p.typed = typed;
        p.known = '0;
        p.known.kind              = kind;
        p.known.row.row_clock     = (kind == ROW_MAIN) ? stamp : 32'd0;
        p.known.row.result_low    = rl;
        p.known.row.result_high   = rh;
        p.known.row.carry_flag    = cf;
        p.known.row.byte_reg_zero = b0;
        p.known.row.byte_reg_one  = b1;
        p.known.row.limbs_low     = ll;
        p.known.row.limbs_high    = lh;
        directed_ops.insert(directed_ops.size(), p);
    endtask

    // Offers one instruction until it is transferred, then records its expected rows.
    task automatic send_alu_op(input alu_op_t p);
        in_data_t   d;
        trace_row_t r0;
        trace_row_t r1;
        int         n;
        d             = '0;
        d.opcode      = p.op;
        d.a_low       = p.al;
        d.a_high      = p.ah;
        d.b_low       = p.bl;
        d.b_high      = p.bh;
        d.clock_stamp = p.stamp;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= p.tag;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n = predict_trace_rows(p.op, p.tag, d, r0, r1);
        if (p.typed)
            r0 = p.known;
        pending_rows.insert(pending_rows.size(), r0);
        if (n == 2)
            pending_rows.insert(pending_rows.size(), r1);
        n_items++;
    endtask

    // Operand with a bias toward zero, the tag maximum and bits above the tag width.
    function automatic word_t pick_operand(input logic [2:0] tag);
        word_t m;
        word_t r;
        m = (tag < TAG_U64) ? ((64'd1 << (8 << tag)) - 64'd1) : ONES;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return '0;
            1:       return m;
            2:       return ONES;
            3, 4:    return r;
            default: return r & m;
        endcase
    endfunction

    // Compares one field and reports a mismatch.
    task automatic check_field(input string what, input word_t want, input word_t got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when asked for one.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                n_holds++;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Each transferred row is checked against the oldest expected row.
    always @(posedge clk)
    begin : row_check
        out_row_t   got;
        trace_row_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_rows.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected row: expected none, actual kind %0d data %h",
                         $time, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_rows.pop_front();
                check_field("row_kind", 64'(want.kind), 64'(m_tuser));
                check_field("row_clock", 64'(want.row.row_clock), 64'(got.row_clock));
                check_field("result_low", want.row.result_low, got.result_low);
                check_field("result_high", want.row.result_high, got.result_high);
                check_field("carry_flag", 64'(want.row.carry_flag), 64'(got.carry_flag));
                check_field("byte_reg_zero", 64'(want.row.byte_reg_zero),
                            64'(got.byte_reg_zero));
                check_field("byte_reg_one", 64'(want.row.byte_reg_one),
                            64'(got.byte_reg_one));
                check_field("limbs_low", want.row.limbs_low, got.limbs_low);
                check_field("limbs_high", want.row.limbs_high, got.limbs_high);
                check_field("partial_word", want.row.partial_word, got.partial_word);
                if (want.kind == ROW_MAIN)
                    n_main++;
                else if (want.kind == ROW_SECOND)
                    n_second++;
                else
                    n_unsup++;
            end
        end
    end

    // Watchdog on cycles in which neither side makes a transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d rows still expected",
                     $time, quiet_cycles, pending_rows.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Reset, directed table, then four random phases with different idling.
    initial
    begin
        alu_op_t p;
        int      ph;
        int      k;
        int      roll;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;

        // Unsupported tags and the reserved opcode give one empty row.
        add_directed(1, OP_ADD, TAG_FIELD, ONES, ONES, ONES, ONES, 32'hFFFF_FFFF,
                     ROW_UNSUP, 0, 0, 0, 0, 0, 0, 0);
        add_directed(1, OP_MUL, TAG_NONE, ONES, ONES, ONES, ONES, 32'hFFFF_FFFF,
                     ROW_UNSUP, 0, 0, 0, 0, 0, 0, 0);
        add_directed(1, OP_SUB, TAG_SEVEN, 64'd5, 64'd6, 64'd7, 64'd8, 32'h1234_5678,
                     ROW_UNSUP, 0, 0, 0, 0, 0, 0, 0);
        add_directed(1, OP_BAD, TAG_U32, ONES, 0, ONES, 0, 32'hFFFF_FFFF,
                     ROW_UNSUP, 0, 0, 0, 0, 0, 0, 0);
        add_directed(1, OP_BAD, TAG_U128, ONES, ONES, ONES, ONES, 32'h0,
                     ROW_UNSUP, 0, 0, 0, 0, 0, 0, 0);
        // Wrap, borrow and full products at the top of each width.
        add_directed(1, OP_ADD, TAG_U8, 64'hFF, 0, 64'h01, 0, 32'h0,
                     ROW_MAIN, 0, 0, 1, 8'h00, 0, 0, 0);
        add_directed(1, OP_SUB, TAG_U8, 64'h00, 0, 64'h01, 0, 32'hFFFF_FFFF,
                     ROW_MAIN, 64'hFF, 0, 1, 8'h00, 0, 0, 0);
        add_directed(1, OP_MUL, TAG_U8, 64'hFF, 0, 64'hFF, 0, 32'h0000_0001,
                     ROW_MAIN, 64'h01, 0, 0, 8'h01, 8'hFE, 0, 0);
        add_directed(1, OP_ADD, TAG_U16, 64'hFFFF, 0, 64'hFFFF, 0, 32'h8000_0000,
                     ROW_MAIN, 64'hFFFE, 0, 1, 0, 0, 64'hFFFE, 0);
        add_directed(1, OP_MUL, TAG_U16, 64'hFFFF, 0, 64'hFFFF, 0, 32'h7FFF_FFFF,
                     ROW_MAIN, 64'h0001, 0, 0, 0, 0, 64'hFFFE_0001, 0);
        add_directed(1, OP_SUB, TAG_U32, 64'h0, 0, 64'hFFFF_FFFF, 0, 32'h0,
                     ROW_MAIN, 64'h1, 0, 1, 0, 0, 64'h0, 0);
        add_directed(1, OP_MUL, TAG_U32, 64'hFFFF_FFFF, 0, 64'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                     ROW_MAIN, 64'h1, 0, 0, 0, 0, 64'hFFFF_FFFE_0000_0001, 0);
        add_directed(1, OP_ADD, TAG_U64, ONES, 0, 64'h1, 0, 32'h0,
                     ROW_MAIN, 0, 0, 1, 0, 0, 0, 0);
        add_directed(1, OP_SUB, TAG_U64, 64'h0, 0, 64'h1, 0, 32'hFFFF_FFFF,
                     ROW_MAIN, ONES, 0, 1, 0, 0, 0, 0);
        add_directed(1, OP_MUL, TAG_U64, ONES, 0, ONES, 0, 32'h0,
                     ROW_MAIN, 64'h1, 0, 0, 0, 0, 64'h1, 64'hFFFF_FFFF_FFFF_FFFE);
        add_directed(1, OP_ADD, TAG_U128, ONES, ONES, 64'h1, 0, 32'hFFFF_FFFF,
                     ROW_MAIN, 0, 0, 1, 0, 0, 0, 0);
        add_directed(1, OP_SUB, TAG_U128, 0, 0, 64'h1, 0, 32'h0,
                     ROW_MAIN, ONES, ONES, 1, 0, 0, 0, 0);
        // Two-row u128 multiplies with all-ones, all-zero and mixed operands.
        add_directed(0, OP_MUL, TAG_U128, ONES, ONES, ONES, ONES, 32'hFFFF_FFFF,
                     ROW_MAIN, 0, 0, 0, 0, 0, 0, 0);
        add_directed(0, OP_MUL, TAG_U128, 0, 0, 0, 0, 32'h0,
                     ROW_MAIN, 0, 0, 0, 0, 0, 0, 0);
        add_directed(0, OP_MUL, TAG_U128, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                     64'h0F0F_0F0F_F0F0_F0F0, 64'h8000_0000_0000_0001, 32'hA5A5_5A5A,
                     ROW_MAIN, 0, 0, 0, 0, 0, 0, 0);
        // Carry across the 64-bit halves.
        add_directed(0, OP_ADD, TAG_U128, ONES, 0, 64'h1, 0, 32'h0000_FFFF,
                     ROW_MAIN, 0, 0, 0, 0, 0, 0, 0);
        // Bits above the tag width must be ignored.
        add_directed(0, OP_ADD, TAG_U8, 64'hFFFF_FFFF_FFFF_FF01, ONES,
                     64'hAAAA_AAAA_AAAA_AA02, ONES, 32'h5555_AAAA,
                     ROW_MAIN, 0, 0, 0, 0, 0, 0, 0);
        add_directed(0, OP_MUL, TAG_U16, 64'h1234_5678_9ABC_FFFF, ONES,
                     64'hFFFF_FFFF_FFFF_8001, ONES, 32'h0F0F_F0F0,
                     ROW_MAIN, 0, 0, 0, 0, 0, 0, 0);
        add_directed(0, OP_SUB, TAG_U32, 64'hFFFF_FFFF_0000_0001, ONES,
                     64'h0000_0001_0000_0002, ONES, 32'hDEAD_BEEF,
                     ROW_MAIN, 0, 0, 0, 0, 0, 0, 0);
        add_directed(0, OP_MUL, TAG_U64, 64'h8000_0000_0000_0001, ONES,
                     64'hC000_0000_0000_0003, ONES, 32'h1,
                     ROW_MAIN, 0, 0, 0, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
            send_alu_op(directed_ops[i]);
        n_directed = n_items;

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (k = 0; k < ITEMS_PER_PH; k++)
            begin
                // Long receiver hold-off while the sender keeps offering.
                if (ph == 0 && k == 100)
                    hold_req = 1'b1;
                roll    = $urandom_range(99);
                p.op    = (roll < 4) ? OP_BAD : 2'($urandom_range(2));
                roll    = $urandom_range(99);
                p.tag   = (roll < 8) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
                p.al    = pick_operand(p.tag);
                p.ah    = pick_operand(TAG_U128);
                p.bl    = pick_operand(p.tag);
                p.bh    = pick_operand(TAG_U128);
                p.stamp = $urandom;
                p.typed = 1'b0;
                p.known = '0;
                send_alu_op(p);
            end
            // Sender pauses until every expected row has arrived.
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending_rows.size() != 0)
                @(posedge clk);
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d instructions (%0d directed) over four idling phases, %0d hold-off(s).",
                 n_items, n_directed, n_holds);
        $display("Checked %0d main, %0d second u128 multiply and %0d unsupported rows.",
                 n_main, n_second, n_unsup);
        if (n_errors == 0 && pending_rows.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
src/tiar_pkg.sv
src/tiar_front.sv
src/tiar_mul_tree.sv
src/tiar_row_out.sv
src/tagged_int_alu_trace_rows_top.sv
src/tiar_checker.sv
test/tb_tagged_int_alu_trace_rows_top.sv
